// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the heap queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define HPQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("heap queue check failed");

// A consequence that holds in the same cycle as its antecedent.
`define HPQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// A consequence that holds in the cycle after its antecedent.
`define HPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`endif

// ===== rtl/hpq_pkg.sv =====
// Types and codes shared by the heap queue modules.
package hpq_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_STEP,
      ST_DN_LAST,
      ST_DN_LOAD,
      ST_DN_READ,
      ST_DN_STEP,
      ST_PLACE,
      ST_FINISH
   } hpq_state_type;

   // Strobes from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic rd_parent;
      logic up_step;
      logic rd_last;
      logic load_last;
      logic rd_child;
      logic dn_step;
      logic place;
      logic publish;
   } hpq_op_type;

   // Conditions reported by the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic last_one;
      logic parent_gt;
      logic parent_root;
      logic leaf;
      logic swap;
   } hpq_flag_type;

endpackage

// ===== rtl/hpq_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface hpq_req_if #(
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [KEY_BITS-1:0]     key;
   logic [PAYLOAD_BITS-1:0] payload;

   modport source (output valid, output cmd, output key, output payload, input ready);
   modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

interface hpq_rsp_if #(
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16,
   parameter int COUNT_BITS   = 9
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [KEY_BITS-1:0]     removed_key;
   logic [PAYLOAD_BITS-1:0] removed_payload;
   logic [KEY_BITS-1:0]     top_key;
   logic [PAYLOAD_BITS-1:0] top_payload;
   logic [COUNT_BITS-1:0]   entry_count;
   logic                    is_empty;

   modport source (output valid, output status, output removed_key, output removed_payload,
                   output top_key, output top_payload, output entry_count, output is_empty,
                   input ready);
   modport sink   (input valid, input status, input removed_key, input removed_payload,
                   input top_key, input top_payload, input entry_count, input is_empty,
                   output ready);
endinterface

// ===== rtl/hpq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module hpq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

// ===== rtl/hpq_ctrl.sv =====
// Sequencing state machine for insert with sift-up and remove with sift-down.
module hpq_ctrl import hpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  hpq_flag_type flag,
   output hpq_op_type   op
);
   hpq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_INSERT) begin
                  if (flag.full) state_in = ST_FINISH;
                  else if (flag.empty) state_in = ST_PLACE;
                  else state_in = ST_UP_READ;
               end else begin
                  if (flag.empty || flag.last_one) state_in = ST_FINISH;
                  else state_in = ST_DN_LAST;
               end
            end
         end
         ST_UP_READ: state_in = ST_UP_STEP;
         ST_UP_STEP: begin
            if (!flag.parent_gt) state_in = ST_FINISH;
            else if (flag.parent_root) state_in = ST_PLACE;
            else state_in = ST_UP_READ;
         end
         ST_DN_LAST: state_in = ST_DN_LOAD;
         ST_DN_LOAD: state_in = ST_DN_READ;
         ST_DN_READ: state_in = flag.leaf ? ST_PLACE : ST_DN_STEP;
         ST_DN_STEP: state_in = flag.swap ? ST_DN_READ : ST_FINISH;
         ST_PLACE:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op        = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            op.start  = req_valid;
         end
         ST_UP_READ: op.rd_parent = 1'b1;
         ST_UP_STEP: op.up_step   = 1'b1;
         ST_DN_LAST: op.rd_last   = 1'b1;
         ST_DN_LOAD: op.load_last = 1'b1;
         ST_DN_READ: op.rd_child  = 1'b1;
         ST_DN_STEP: op.dn_step   = 1'b1;
         ST_PLACE:   op.place     = 1'b1;
         ST_FINISH:  op.publish   = out_free;
         default: ;
      endcase
   end

   // The response register is loaded on publish and drained by a transfer.
   always_comb begin
      if (op.publish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/hpq_dpath.sv =====
// Heap datapath: entry memory, hole position, moving entry, count, root copy, result.
module hpq_dpath import hpq_pkg::*; #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hpq_op_type                       op,
   output hpq_flag_type                     flag,
   input  logic                             req_cmd,
   input  logic [KEY_BITS-1:0]              req_key,
   input  logic [PAYLOAD_BITS-1:0]          req_payload,
   output logic [1:0]                       rsp_status,
   output logic [KEY_BITS-1:0]              rsp_removed_key,
   output logic [PAYLOAD_BITS-1:0]          rsp_removed_payload,
   output logic [KEY_BITS-1:0]              rsp_top_key,
   output logic [PAYLOAD_BITS-1:0]          rsp_top_payload,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   output logic                             rsp_is_empty
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = AW + 2;
   localparam int EW = KEY_BITS + PAYLOAD_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [EW-1:0] hold_ff, hold_in;
   logic [EW-1:0] top_ff, top_in;
   logic [1:0]    status_ff, status_in;
   logic [EW-1:0] removed_ff, removed_in;

   logic [1:0]    out_status_ff;
   logic [EW-1:0] out_removed_ff;
   logic [EW-1:0] out_top_ff;
   logic [CW-1:0] out_count_ff;
   logic          out_empty_ff;

   logic [AW-1:0] parent;
   logic [IW-1:0] l_idx, r_idx, count_ext;
   logic          has_right, pick_right;
   logic [AW-1:0] pick;
   logic [EW-1:0] rd_a, rd_b, pick_data;
   logic [KEY_BITS-1:0] hold_key, a_key, b_key;

   logic          wr_en;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr_a;

   assign hold_key  = hold_ff[EW-1:PAYLOAD_BITS];
   assign a_key     = rd_a[EW-1:PAYLOAD_BITS];
   assign b_key     = rd_b[EW-1:PAYLOAD_BITS];

   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign l_idx     = {1'b0, pos_ff, 1'b1};
   assign r_idx     = {1'b0, pos_ff, 1'b0} + IW'(2);
   assign count_ext = IW'(count_ff);
   assign has_right = r_idx < count_ext;
   // On equal child keys the right child moves up.
   assign pick_right = has_right && !(b_key > a_key) && !(a_key < b_key);
   assign pick       = pick_right ? AW'(r_idx) : AW'(l_idx);
   assign pick_data  = pick_right ? rd_b : rd_a;

   assign flag.full        = count_ff == CW'(DEPTH);
   assign flag.empty       = count_ff == '0;
   assign flag.last_one    = count_ff == CW'(1);
   assign flag.parent_gt   = a_key > hold_key;
   assign flag.parent_root = parent == '0;
   assign flag.leaf        = l_idx >= count_ext;
   assign flag.swap        = has_right ? (hold_key > a_key || hold_key > b_key)
                                       : (hold_key > a_key);

   always_comb begin
      if (op.rd_parent) rd_addr_a = parent;
      else if (op.rd_last) rd_addr_a = AW'(count_ff);
      else if (op.rd_child) rd_addr_a = AW'(l_idx);
      else rd_addr_a = '0;
   end

   // The moving entry stays in a register; each step writes one entry into the hole.
   assign wr_en = op.place || op.up_step || op.dn_step;
   always_comb begin
      if (op.up_step && flag.parent_gt) wr_data = rd_a;
      else if (op.dn_step && flag.swap) wr_data = pick_data;
      else wr_data = hold_ff;
   end

   hpq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (AW'(r_idx)),
      .rd_data_b (rd_b)
   );

   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      top_in     = top_ff;
      status_in  = status_ff;
      removed_in = removed_ff;

      if (op.start) begin
         status_in  = STATUS_OK;
         removed_in = '0;
         if (req_cmd == CMD_INSERT) begin
            if (flag.full) begin
               status_in = STATUS_FULL;
            end else begin
               hold_in  = {req_key, req_payload};
               pos_in   = AW'(count_ff);
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (flag.empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in = top_ff;
               count_in   = count_ff - CW'(1);
            end
         end
      end

      if (op.load_last) begin
         hold_in = rd_a;
         pos_in  = '0;
      end
      if (op.up_step && flag.parent_gt) pos_in = parent;
      if (op.dn_step && flag.swap) pos_in = pick;

      if (wr_en && pos_ff == '0) top_in = wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      hold_ff    <= hold_in;
      top_ff     <= top_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (op.publish) begin
         out_status_ff  <= status_ff;
         out_removed_ff <= removed_ff;
         out_top_ff     <= (count_ff == '0) ? '0 : top_ff;
         out_count_ff   <= count_ff;
         out_empty_ff   <= count_ff == '0;
      end
   end

   assign rsp_status          = out_status_ff;
   assign rsp_removed_key     = out_removed_ff[EW-1:PAYLOAD_BITS];
   assign rsp_removed_payload = out_removed_ff[PAYLOAD_BITS-1:0];
   assign rsp_top_key         = out_top_ff[EW-1:PAYLOAD_BITS];
   assign rsp_top_payload     = out_top_ff[PAYLOAD_BITS-1:0];
   assign rsp_entry_count     = out_count_ff;
   assign rsp_is_empty        = out_empty_ff;
endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue with insert and remove-min over valid/ready channels.
// Each request is one insert or one remove-min and yields exactly one response carrying a
// status code, the removed entry (zero unless a remove succeeded), the root entry after the
// operation (zero when empty), the entry count and an empty flag. Requests are handled one at
// a time. An insert starts the new entry at the end of the heap and climbs it one level at a
// time while its parent key is strictly greater; a remove moves the last entry to the root
// and sinks it one level at a time while a child key is smaller. An insert into an empty
// heap writes the root directly; a rejected request or a remove that empties the heap goes
// straight to the response. The pace is set by the round trip through the single
// registered-read entry memory, which is read and written once per heap level. The entry
// memory needs no clearing after reset. A finished response sits in an output register, so
// a new request is taken while the previous response still waits for its transfer.
module binary_min_heap_priority_queue import hpq_pkg::*; #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   hpq_req_if.sink   req_chan,
   hpq_rsp_if.source rsp_chan
);
   hpq_op_type   op;
   hpq_flag_type flag;

   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .flag      (flag),
      .op        (op)
   );

   hpq_dpath #(
      .DEPTH        (DEPTH),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .flag                (flag),
      .req_cmd             (req_chan.cmd),
      .req_key             (req_chan.key),
      .req_payload         (req_chan.payload),
      .rsp_status          (rsp_chan.status),
      .rsp_removed_key     (rsp_chan.removed_key),
      .rsp_removed_payload (rsp_chan.removed_payload),
      .rsp_top_key         (rsp_chan.top_key),
      .rsp_top_payload     (rsp_chan.top_payload),
      .rsp_entry_count     (rsp_chan.entry_count),
      .rsp_is_empty        (rsp_chan.is_empty)
   );
endmodule

// ===== rtl/hpq_checker.sv =====
// Port-level checks on the heap queue responses, bound to the top level.
`include "assert_macros.svh"

module hpq_checker import hpq_pkg::*; #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [KEY_BITS-1:0]         rsp_removed_key,
   input logic [PAYLOAD_BITS-1:0]     rsp_removed_payload,
   input logic [KEY_BITS-1:0]         rsp_top_key,
   input logic [PAYLOAD_BITS-1:0]     rsp_top_payload,
   input logic [$clog2(DEPTH+1)-1:0]  rsp_entry_count,
   input logic                        rsp_is_empty
);
   localparam int CW = $clog2(DEPTH + 1);

   // A stalled response keeps its status, root key and entry count until the transfer.
   `HPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_top_key) && $stable(rsp_entry_count))

   `HPQ_ASSERT_IMPLIES(a_empty_flag, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))

   `HPQ_ASSERT_IMPLIES(a_empty_top, clock, reset, rsp_valid && rsp_is_empty, rsp_top_key == '0 && rsp_top_payload == '0)

   // A rejected operation never reports a removed entry.
   `HPQ_ASSERT_IMPLIES(a_reject_clean, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_removed_key == '0 && rsp_removed_payload == '0)

   `HPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, !rsp_valid || rsp_entry_count <= CW'(DEPTH))
endmodule

bind binary_min_heap_priority_queue hpq_checker #(
   .DEPTH        (DEPTH),
   .KEY_BITS     (KEY_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_hpq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_removed_key     (rsp_chan.removed_key),
   .rsp_removed_payload (rsp_chan.removed_payload),
   .rsp_top_key         (rsp_chan.top_key),
   .rsp_top_payload     (rsp_chan.top_payload),
   .rsp_entry_count     (rsp_chan.entry_count),
   .rsp_is_empty        (rsp_chan.is_empty)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 1ps

module tb_top;
   import hpq_pkg::*;

   localparam int DEPTH        = 256;
   localparam int KEY_BITS     = 24;
   localparam int PAYLOAD_BITS = 16;
   localparam int COUNT_BITS   = 9;
   localparam int DRAIN_CYCLES = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 600000;

   typedef struct packed {
      logic [1:0]              status;
      logic [KEY_BITS-1:0]     removed_key;
      logic [PAYLOAD_BITS-1:0] removed_payload;
      logic [KEY_BITS-1:0]     top_key;
      logic [PAYLOAD_BITS-1:0] top_payload;
      logic [COUNT_BITS-1:0]   entry_count;
      logic                    is_empty;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpq_req_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) req_if ();
   hpq_rsp_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS), .COUNT_BITS(COUNT_BITS))
      rsp_if ();

   binary_min_heap_priority_queue #(
      .DEPTH(DEPTH),
      .KEY_BITS(KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // Shadow copy of the heap, updated at every accepted request.
   logic [KEY_BITS-1:0]     heap_keys [DEPTH];
   logic [PAYLOAD_BITS-1:0] heap_pays [DEPTH];
   int                      heap_count = 0;

   heap_result_type pending_results [$];
   int              error_count   = 0;
   int              cycle_count   = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            rsp_hold      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void swap_entries(input int a, input int b);
      logic [KEY_BITS-1:0]     k;
      logic [PAYLOAD_BITS-1:0] p;
      k = heap_keys[a];
      p = heap_pays[a];
      heap_keys[a] = heap_keys[b];
      heap_pays[a] = heap_pays[b];
      heap_keys[b] = k;
      heap_pays[b] = p;
   endfunction

   function automatic heap_result_type apply_to_heap(input logic cmd,
                                                     input logic [KEY_BITS-1:0] key,
                                                     input logic [PAYLOAD_BITS-1:0] payload);
      heap_result_type res;
      int pos, up, lt, rt, pick;
      res = '0;
      res.status = STATUS_OK;
      if (cmd == CMD_INSERT) begin
         if (heap_count >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            heap_keys[heap_count] = key;
            heap_pays[heap_count] = payload;
            pos = heap_count;
            heap_count++;
            // Climb only while the parent is strictly greater.
            while (pos != 0) begin
               up = (pos - 1) / 2;
               if (heap_keys[up] <= heap_keys[pos]) break;
               swap_entries(up, pos);
               pos = up;
            end
         end
      end else if (heap_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.removed_key     = heap_keys[0];
         res.removed_payload = heap_pays[0];
         heap_count--;
         heap_keys[0] = heap_keys[heap_count];
         heap_pays[0] = heap_pays[heap_count];
         pos = 0;
         while (2 * pos + 1 < heap_count) begin
            lt = 2 * pos + 1;
            rt = lt + 1;
            if (rt < heap_count) begin
               if (!(heap_keys[pos] > heap_keys[lt] || heap_keys[pos] > heap_keys[rt])) break;
               // Equal children send the entry to the right.
               pick = (heap_keys[lt] < heap_keys[rt]) ? lt : rt;
            end else begin
               if (!(heap_keys[pos] > heap_keys[lt])) break;
               pick = lt;
            end
            swap_entries(pos, pick);
            pos = pick;
         end
      end
      if (heap_count != 0) begin
         res.top_key     = heap_keys[0];
         res.top_payload = heap_pays[0];
      end
      res.entry_count = COUNT_BITS'(heap_count);
      res.is_empty    = (heap_count == 0);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Response side: random ready and comparison of every transfer.
   always @(posedge clock) begin : response_check
      heap_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_if.status));
               check_field("removed_key", 32'(want.removed_key), 32'(rsp_if.removed_key));
               check_field("removed_payload", 32'(want.removed_payload),
                           32'(rsp_if.removed_payload));
               check_field("top_key", 32'(want.top_key), 32'(rsp_if.top_key));
               check_field("top_payload", 32'(want.top_payload), 32'(rsp_if.top_payload));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_if.is_empty));
            end
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("binary_min_heap_priority_queue test failed");
         $finish;
      end
   end

   // Offers one request and returns at the edge of its transfer, valid left high.
   task automatic send_item(input logic cmd, input logic [KEY_BITS-1:0] key,
                            input logic [PAYLOAD_BITS-1:0] payload);
      heap_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.key     <= key;
      req_if.payload <= payload;
      do @(posedge clock); while (!req_if.ready);
      res = apply_to_heap(cmd, key, payload);
      pending_results.push_back(res);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Small keys are favored so that ties come up often.
   function automatic logic [KEY_BITS-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 25) return KEY_BITS'($urandom_range(7));
      else if (sel < 30) return '0;
      else if (sel < 35) return '1;
      else return KEY_BITS'($urandom);
   endfunction

   task automatic test_directed_cases();
      send_item(CMD_REMOVE, '1, '1);
      send_item(CMD_INSERT, 24'h000000, 16'h0000);
      send_item(CMD_INSERT, 24'hFFFFFF, 16'hFFFF);
      send_item(CMD_INSERT, 24'hAAAAAA, 16'h5555);
      send_item(CMD_INSERT, 24'h555555, 16'hAAAA);
      // An equal key must not displace the current root.
      send_item(CMD_INSERT, 24'h000000, 16'h1234);
      repeat (6) send_item(CMD_REMOVE, 24'h0, 16'h0);
      // Two equal children under the root: the right one must rise.
      send_item(CMD_INSERT, 24'd5, 16'h0001);
      send_item(CMD_INSERT, 24'd9, 16'h0002);
      send_item(CMD_INSERT, 24'd9, 16'h0003);
      send_item(CMD_INSERT, 24'd20, 16'h0004);
      repeat (4) send_item(CMD_REMOVE, 24'h0, 16'h0);
      // Root left with a single, smaller child after the remove.
      send_item(CMD_INSERT, 24'd1, 16'h0011);
      send_item(CMD_INSERT, 24'd5, 16'h0022);
      send_item(CMD_INSERT, 24'd7, 16'h0033);
      repeat (3) send_item(CMD_REMOVE, 24'h0, 16'h0);
      wait_drained();
   endtask

   task automatic test_fill_to_full_and_drain();
      while (heap_count < DEPTH) send_item(CMD_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
      repeat (3) send_item(CMD_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
      while (heap_count > 0) send_item(CMD_REMOVE, pick_key(), PAYLOAD_BITS'($urandom));
      repeat (2) send_item(CMD_REMOVE, pick_key(), PAYLOAD_BITS'($urandom));
      wait_drained();
   endtask

   // Runs of insert-heavy and remove-heavy traffic so the fill level wanders.
   task automatic test_random_traffic(input int n);
      int   run_left;
      bit   favor_insert;
      logic cmd;
      run_left = 0;
      favor_insert = 1'b1;
      repeat (n) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            favor_insert = 1'($urandom_range(1));
         end
         run_left--;
         if (($urandom_range(99) < 70) == favor_insert) cmd = CMD_INSERT;
         else cmd = CMD_REMOVE;
         send_item(cmd, pick_key(), PAYLOAD_BITS'($urandom));
      end
      wait_drained();
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      fork
         begin
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            repeat (12) send_item(CMD_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
         end
      join
      wait_drained();
      repeat (12) send_item(CMD_REMOVE, pick_key(), PAYLOAD_BITS'($urandom));
      wait_drained();
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.cmd     <= CMD_INSERT;
      req_if.key     <= '0;
      req_if.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(33, 80);
      test_directed_cases();
      test_random_traffic(170);
      test_output_backpressure();

      set_idling(80, 33);
      test_fill_to_full_and_drain();
      test_random_traffic(170);

      set_idling(0, 0);
      test_random_traffic(170);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("binary_min_heap_priority_queue test passed");
      end else begin
         $display("binary_min_heap_priority_queue test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hpq_pkg.sv
rtl/hpq_if.sv
rtl/hpq_ram.sv
rtl/hpq_ctrl.sv
rtl/hpq_dpath.sv
rtl/binary_min_heap_priority_queue.sv
rtl/hpq_checker.sv
tb/sv/tb_top.sv
